### hw/rtl/sgu_pkg.sv
// ----------------------------------------------------------------------------
// sgu_pkg
// Shared constants for the segment usage classifier: field widths,
// function codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package sgu_pkg;

  // fixed field widths
  localparam int FUNC_W    = 2;
  localparam int AMOUNT_W  = 22;
  localparam int MAXC_W    = 5;
  localparam int BYTES_W   = 21;
  localparam int LOG2_W    = 5;
  localparam int FREE_W    = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 21;

  // default sizing
  localparam int DEF_NUM_SEGMENTS = 1024;
  localparam int DEF_MAX_BATCH    = 16;

  // function codes
  localparam logic [FUNC_W-1:0] FN_SET_USAGE   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_TAKE_CLEAN  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_LIST_CLEAN  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_APPLY_LEVEL = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEG_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LOG2 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRTY_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAN_FLR  = 2'd3;

  // register reset values
  localparam logic [BYTES_W-1:0] RST_SEG_BYTES  = 21'd524288;
  localparam logic [LOG2_W-1:0]  RST_BLOCK_LOG2 = 5'd12;
  localparam logic [BYTES_W-1:0] RST_DIRTY_THR  = 21'd262144;
  localparam logic [BYTES_W-1:0] RST_CLEAN_FLR  = 21'd0;

  // list selector codes
  localparam logic [1:0] LST_NONE  = 2'd0;
  localparam logic [1:0] LST_CLEAN = 2'd1;
  localparam logic [1:0] LST_DIRTY = 2'd2;

  // class mark bits
  localparam int MK_CLEAN = 0;
  localparam int MK_DIRTY = 1;

endpackage

`default_nettype wire

### hw/rtl/segment_usage_classifier.sv
// ----------------------------------------------------------------------------
// segment_usage_classifier
// Per-segment live-byte table with clean and dirty linked lists and a
// running free-block total.
// ----------------------------------------------------------------------------
// Works on one transaction at a time. After reset the block sweeps its
// segment memory with in_tready low. Segment state (live bytes, class
// marks) and list links live in two single-port-read synchronous memories,
// so every read is registered. A set usage or take clean steps through
// read, compute, block conversion, two unlink writes, append, write back
// and result. List cleanable walks the dirty list, reading and testing each
// entry. Apply dirty level scans every segment, reading and testing each,
// and re-sorts each one that qualifies through the set usage steps. Results
// go to an output register, so the next transaction may be taken while a
// result still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_usage_classifier #(
  parameter int NUM_SEGMENTS = sgu_pkg::DEF_NUM_SEGMENTS,
  parameter int MAX_BATCH    = sgu_pkg::DEF_MAX_BATCH,
  localparam int IDX_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1,
  localparam int LNK_W  = $clog2(NUM_SEGMENTS + 1),
  localparam int FC_W   = $clog2(MAX_BATCH + 1),
  localparam int IN_BITS  = sgu_pkg::FUNC_W + IDX_W + sgu_pkg::AMOUNT_W + sgu_pkg::MAXC_W,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 1 + 5 * LNK_W + FC_W + sgu_pkg::FREE_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // configuration write port
  input  wire                            cfg_wr_en,
  input  wire [sgu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [sgu_pkg::CFG_W-1:0]       cfg_wdata,
  // input channel
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [IN_W-1:0]                 in_tdata,   // func, segment, amount, max_count
  // result channel
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [OUT_W-1:0]               out_tdata,  // status, segment_out, prev_segment,
                                                     // next_clean, found_count,
                                                     // free_blocks, clean_count,
                                                     // dirty_count
  output logic                           out_tlast
);

  import sgu_pkg::*;

  localparam logic [LNK_W-1:0] NONE    = LNK_W'(NUM_SEGMENTS);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(NUM_SEGMENTS - 1);
  localparam int SEGW_W = BYTES_W + 2;
  localparam int CMP_W  = (FC_W > MAXC_W) ? FC_W : MAXC_W;
  localparam int SUM_W  = FREE_W + 2;

  // sequencer states
  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_RD        = 5'd2;
  localparam logic [4:0] S_CALC      = 5'd3;
  localparam logic [4:0] S_FREE      = 5'd4;
  localparam logic [4:0] S_RM1       = 5'd5;
  localparam logic [4:0] S_RM2       = 5'd6;
  localparam logic [4:0] S_AP        = 5'd7;
  localparam logic [4:0] S_SEGW      = 5'd8;
  localparam logic [4:0] S_DONE      = 5'd9;
  localparam logic [4:0] S_EMIT      = 5'd10;
  localparam logic [4:0] S_WALK_RD   = 5'd11;
  localparam logic [4:0] S_WALK_CHK  = 5'd12;
  localparam logic [4:0] S_WALK_SWAP = 5'd13;
  localparam logic [4:0] S_WALK_DEC  = 5'd14;
  localparam logic [4:0] S_SCAN_RD   = 5'd15;
  localparam logic [4:0] S_SCAN_CHK  = 5'd16;
  localparam logic [4:0] S_SCAN_NXT  = 5'd17;

  typedef struct packed {
    logic [LNK_W-1:0] nxt;
    logic [LNK_W-1:0] prv;
  } link_t;

  // memories
  logic [SEGW_W-1:0] seg_mem  [NUM_SEGMENTS];
  link_t             link_mem [NUM_SEGMENTS];
  logic [SEGW_W-1:0] seg_rd_q;
  link_t             link_rd_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              seg_we;
  logic [IDX_W-1:0]  seg_wa;
  logic [SEGW_W-1:0] seg_wd;
  logic              lk_we_n, lk_we_p;
  logic [IDX_W-1:0]  lk_wa;
  logic [LNK_W-1:0]  lk_wd_n, lk_wd_p;

  // configuration registers
  logic [BYTES_W-1:0] seg_bytes_r, thr_r, floor_r;
  logic [LOG2_W-1:0]  bsl_r;

  // control and datapath registers
  logic [4:0]                state_r, state_nxt;
  logic [FUNC_W-1:0]         func_r, func_nxt;
  logic [IDX_W-1:0]          seg_r, seg_nxt;
  logic signed [AMOUNT_W-1:0] amt_r, amt_nxt;
  logic [LNK_W-1:0]          prev_r, prev_nxt;
  logic [LNK_W-1:0]          cur_r, cur_nxt;
  logic [LNK_W-1:0]          chead_r, chead_nxt, ctail_r, ctail_nxt;
  logic [LNK_W-1:0]          dhead_r, dhead_nxt, dtail_r, dtail_nxt;
  logic [LNK_W-1:0]          ccnt_r, ccnt_nxt, dcnt_r, dcnt_nxt;
  logic signed [FREE_W-1:0]  free_r, free_nxt;
  logic [BYTES_W-1:0]        nv_r, nv_nxt, diff_r, diff_nxt;
  logic                      dec_r, dec_nxt;
  logic [1:0]                mk_r, mk_nxt, rm_r, rm_nxt, ap_r, ap_nxt;
  logic [LNK_W-1:0]          p_r, p_nxt, n_r, n_nxt, ptail_r, ptail_nxt;
  logic [BYTES_W:0]          blocks_r, blocks_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [LNK_W-1:0]          walk_r, walk_nxt;
  logic [FC_W-1:0]           found_r, found_nxt, limit_r, limit_nxt;
  logic                      pend_v_r, pend_v_nxt;
  logic [LNK_W-1:0]          pend_seg_r, pend_seg_nxt, cand_seg_r, cand_seg_nxt;
  logic [FC_W-1:0]           pend_pos_r, pend_pos_nxt, cand_pos_r, cand_pos_nxt;
  logic                      em_status_r, em_status_nxt, em_last_r, em_last_nxt;
  logic [LNK_W-1:0]          em_seg_r, em_seg_nxt, em_prev_r, em_prev_nxt;
  logic [LNK_W-1:0]          em_next_r, em_next_nxt;
  logic [FC_W-1:0]           em_found_r, em_found_nxt;
  logic [4:0]                em_ret_r, em_ret_nxt;
  logic                      out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [OUT_W-1:0]          out_data_r, out_data_nxt;

  // input field unpack
  logic [FUNC_W-1:0]          in_func;
  logic [IDX_W-1:0]           in_seg;
  logic signed [AMOUNT_W-1:0] in_amt;
  logic [MAXC_W-1:0]          in_maxc;
  assign in_func = in_tdata[FUNC_W-1:0];
  assign in_seg  = in_tdata[FUNC_W +: IDX_W];
  assign in_amt  = in_tdata[FUNC_W + IDX_W +: AMOUNT_W];
  assign in_maxc = in_tdata[FUNC_W + IDX_W + AMOUNT_W +: MAXC_W];

  // read data views
  logic [BYTES_W-1:0] rd_live;
  logic [1:0]         rd_mk;
  assign rd_live = seg_rd_q[SEGW_W-1:2];
  assign rd_mk   = seg_rd_q[1:0];

  // handshake outputs
  logic out_free;
  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // new count and byte difference
  logic signed [BYTES_W+1:0] sum_sg;
  logic [BYTES_W-1:0]        calc_nv;
  logic                      calc_le;
  assign sum_sg = $signed({2'b00, rd_live}) + $signed({amt_r[AMOUNT_W-1], amt_r});
  always_comb begin
    if (amt_r == '0) begin
      calc_nv = '0;
    end else if (amt_r[AMOUNT_W-1]) begin
      calc_nv = (sum_sg <= 0) ? BYTES_W'(1) : sum_sg[BYTES_W-1:0];
    end else begin
      calc_nv = amt_r[BYTES_W-1:0];
    end
  end
  assign calc_le = (calc_nv <= thr_r);

  // bytes to blocks, rounded to nearest
  logic [31:0] half_b, round_b, shift_b;
  assign half_b  = (bsl_r == '0) ? 32'd0 : (32'd1 << (bsl_r - LOG2_W'(1)));
  assign round_b = {{(32 - BYTES_W){1'b0}}, diff_r} + half_b;
  assign shift_b = round_b >> bsl_r;

  // saturating free-block update
  logic signed [SUM_W-1:0] free_ext, blk_ext, free_sum;
  localparam logic signed [SUM_W-1:0] FB_MAX = SUM_W'((1 << (FREE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] FB_MIN = -SUM_W'(1 << (FREE_W - 1));
  assign free_ext = SUM_W'(free_r);
  assign blk_ext  = $signed(SUM_W'(blocks_r));
  assign free_sum = dec_r ? (free_ext - blk_ext) : (free_ext + blk_ext);

  // batch limit
  logic [FC_W-1:0] in_limit;
  assign in_limit = (CMP_W'(in_maxc) >= CMP_W'(MAX_BATCH)) ? FC_W'(MAX_BATCH)
                                                           : FC_W'(in_maxc);

  // sequencer
  always_comb begin
    state_nxt = state_r;  func_nxt = func_r;  seg_nxt = seg_r;  amt_nxt = amt_r;
    prev_nxt = prev_r;  cur_nxt = cur_r;
    chead_nxt = chead_r;  ctail_nxt = ctail_r;  dhead_nxt = dhead_r;  dtail_nxt = dtail_r;
    ccnt_nxt = ccnt_r;  dcnt_nxt = dcnt_r;  free_nxt = free_r;
    nv_nxt = nv_r;  diff_nxt = diff_r;  dec_nxt = dec_r;  mk_nxt = mk_r;
    rm_nxt = rm_r;  ap_nxt = ap_r;  p_nxt = p_r;  n_nxt = n_r;  ptail_nxt = ptail_r;
    blocks_nxt = blocks_r;  idx_nxt = idx_r;  walk_nxt = walk_r;
    found_nxt = found_r;  limit_nxt = limit_r;  pend_v_nxt = pend_v_r;
    pend_seg_nxt = pend_seg_r;  pend_pos_nxt = pend_pos_r;
    cand_seg_nxt = cand_seg_r;  cand_pos_nxt = cand_pos_r;
    em_status_nxt = em_status_r;  em_last_nxt = em_last_r;  em_seg_nxt = em_seg_r;
    em_prev_nxt = em_prev_r;  em_next_nxt = em_next_r;  em_found_nxt = em_found_r;
    em_ret_nxt = em_ret_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt = out_last_r;  out_data_nxt = out_data_r;
    rd_addr = seg_r;
    seg_we = 1'b0;  seg_wa = seg_r;  seg_wd = {nv_r, mk_r};
    lk_we_n = 1'b0;  lk_we_p = 1'b0;  lk_wa = seg_r;  lk_wd_n = NONE;  lk_wd_p = NONE;

    case (state_r)
      // clearing pass after reset
      S_CLEAR: begin
        seg_we = 1'b1;  seg_wa = idx_r;  seg_wd = '0;
        lk_we_n = 1'b1;  lk_we_p = 1'b1;  lk_wa = idx_r;
        if (idx_r == IDX_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      // take a transaction
      S_IDLE: begin
        em_status_nxt = 1'b0;  em_last_nxt = 1'b1;  em_seg_nxt = NONE;
        em_prev_nxt = NONE;  em_next_nxt = NONE;  em_found_nxt = '0;
        em_ret_nxt = S_IDLE;
        if (in_tvalid) begin
          func_nxt = in_func;
          case (in_func)
            FN_SET_USAGE: begin
              seg_nxt = in_seg;  amt_nxt = in_amt;
              state_nxt = (LNK_W'(in_seg) < NONE) ? S_RD : S_EMIT;
            end
            FN_TAKE_CLEAN: begin
              prev_nxt = cur_r;
              if (chead_r == NONE) begin
                em_status_nxt = 1'b1;  em_prev_nxt = cur_r;  state_nxt = S_EMIT;
              end else begin
                cur_nxt = chead_r;  seg_nxt = chead_r[IDX_W-1:0];
                amt_nxt = $signed({1'b0, seg_bytes_r});
                state_nxt = S_RD;
              end
            end
            FN_LIST_CLEAN: begin
              limit_nxt = in_limit;  found_nxt = '0;  pend_v_nxt = 1'b0;
              walk_nxt = (in_limit == '0) ? NONE : dhead_r;
              state_nxt = S_WALK_RD;
            end
            default: begin
              idx_nxt = '0;  state_nxt = S_SCAN_RD;
            end
          endcase
        end
      end

      // set usage: read segment entry
      S_RD: begin
        rd_addr = seg_r;  state_nxt = S_CALC;
      end

      // set usage: new count, marks and list moves
      S_CALC: begin
        nv_nxt = calc_nv;
        dec_nxt = (calc_nv > rd_live);
        diff_nxt = (calc_nv > rd_live) ? (calc_nv - rd_live) : (rd_live - calc_nv);
        p_nxt = link_rd_q.prv;  n_nxt = link_rd_q.nxt;
        if (amt_r == '0) begin
          rm_nxt = rd_mk[MK_DIRTY] ? LST_DIRTY : LST_NONE;
          ap_nxt = rd_mk[MK_CLEAN] ? LST_NONE : LST_CLEAN;
          mk_nxt = 2'b01;
          ptail_nxt = ctail_r;
        end else begin
          if (rd_mk[MK_CLEAN]) begin
            rm_nxt = LST_CLEAN;
          end else if (!calc_le && rd_mk[MK_DIRTY]) begin
            rm_nxt = LST_DIRTY;
          end else begin
            rm_nxt = LST_NONE;
          end
          ap_nxt = (calc_le && !rd_mk[MK_DIRTY]) ? LST_DIRTY : LST_NONE;
          mk_nxt = {calc_le, 1'b0};
          ptail_nxt = dtail_r;
        end
        state_nxt = S_FREE;
      end

      // set usage: convert byte change to blocks
      S_FREE: begin
        blocks_nxt = shift_b[BYTES_W:0];  state_nxt = S_RM1;
      end

      // unlink, forward side; apply free total
      S_RM1: begin
        if (free_sum > FB_MAX) begin
          free_nxt = FB_MAX[FREE_W-1:0];
        end else if (free_sum < FB_MIN) begin
          free_nxt = FB_MIN[FREE_W-1:0];
        end else begin
          free_nxt = free_sum[FREE_W-1:0];
        end
        if (rm_r != LST_NONE) begin
          if (p_r != NONE) begin
            lk_we_n = 1'b1;  lk_wa = p_r[IDX_W-1:0];  lk_wd_n = n_r;
          end else if (rm_r == LST_CLEAN) begin
            chead_nxt = n_r;
          end else begin
            dhead_nxt = n_r;
          end
        end
        state_nxt = S_RM2;
      end

      // unlink, backward side
      S_RM2: begin
        if (rm_r != LST_NONE) begin
          if (n_r != NONE) begin
            lk_we_p = 1'b1;  lk_wa = n_r[IDX_W-1:0];  lk_wd_p = p_r;
          end else if (rm_r == LST_CLEAN) begin
            ctail_nxt = p_r;
          end else begin
            dtail_nxt = p_r;
          end
          if (rm_r == LST_CLEAN) begin
            ccnt_nxt = ccnt_r - LNK_W'(1);
          end else begin
            dcnt_nxt = dcnt_r - LNK_W'(1);
          end
        end
        state_nxt = S_AP;
      end

      // append at tail
      S_AP: begin
        if (ap_r != LST_NONE) begin
          if (ptail_r != NONE) begin
            lk_we_n = 1'b1;  lk_wa = ptail_r[IDX_W-1:0];  lk_wd_n = LNK_W'(seg_r);
          end else if (ap_r == LST_CLEAN) begin
            chead_nxt = LNK_W'(seg_r);
          end else begin
            dhead_nxt = LNK_W'(seg_r);
          end
          if (ap_r == LST_CLEAN) begin
            ctail_nxt = LNK_W'(seg_r);  ccnt_nxt = ccnt_r + LNK_W'(1);
          end else begin
            dtail_nxt = LNK_W'(seg_r);  dcnt_nxt = dcnt_r + LNK_W'(1);
          end
        end
        state_nxt = S_SEGW;
      end

      // write back segment entry and own links
      S_SEGW: begin
        seg_we = 1'b1;
        if (rm_r != LST_NONE || ap_r != LST_NONE) begin
          lk_we_n = 1'b1;  lk_we_p = 1'b1;
          lk_wd_p = (ap_r != LST_NONE) ? ptail_r : NONE;
        end
        state_nxt = S_DONE;
      end

      // set usage finished
      S_DONE: begin
        if (func_r == FN_APPLY_LEVEL) begin
          state_nxt = S_SCAN_NXT;
        end else begin
          em_seg_nxt = LNK_W'(seg_r);
          if (func_r == FN_TAKE_CLEAN) begin
            em_prev_nxt = prev_r;  em_next_nxt = chead_r;
          end
          em_ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end
      end

      // load result register
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt = em_last_r;
          out_data_nxt = OUT_W'({dcnt_r, ccnt_r, free_r, em_found_r, em_next_r,
                                 em_prev_r, em_seg_r, em_status_r});
          state_nxt = em_ret_r;
        end
      end

      // dirty list walk: read next entry
      S_WALK_RD: begin
        rd_addr = walk_r[IDX_W-1:0];
        em_ret_nxt = S_IDLE;  em_last_nxt = 1'b1;
        if (walk_r == NONE) begin
          if (pend_v_r) begin
            em_seg_nxt = pend_seg_r;  em_found_nxt = pend_pos_r;
          end else begin
            em_seg_nxt = NONE;  em_found_nxt = '0;
          end
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_WALK_CHK;
        end
      end

      // dirty list walk: test entry against floor
      S_WALK_CHK: begin
        walk_nxt = link_rd_q.nxt;
        if (rd_live > floor_r) begin
          found_nxt = found_r + FC_W'(1);
          if (pend_v_r) begin
            cand_seg_nxt = walk_r;  cand_pos_nxt = found_r + FC_W'(1);
            em_seg_nxt = pend_seg_r;  em_found_nxt = pend_pos_r;
            em_last_nxt = 1'b0;  em_ret_nxt = S_WALK_SWAP;
            state_nxt = S_EMIT;
          end else begin
            pend_v_nxt = 1'b1;  pend_seg_nxt = walk_r;  pend_pos_nxt = found_r + FC_W'(1);
            state_nxt = S_WALK_DEC;
          end
        end else begin
          state_nxt = S_WALK_RD;
        end
      end

      // candidate becomes pending
      S_WALK_SWAP: begin
        pend_seg_nxt = cand_seg_r;  pend_pos_nxt = cand_pos_r;
        state_nxt = S_WALK_DEC;
      end

      // stop at the batch limit
      S_WALK_DEC: begin
        if (found_r == limit_r) begin
          em_seg_nxt = pend_seg_r;  em_found_nxt = pend_pos_r;
          em_last_nxt = 1'b1;  em_ret_nxt = S_IDLE;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_WALK_RD;
        end
      end

      // level scan: read entry
      S_SCAN_RD: begin
        rd_addr = idx_r;  state_nxt = S_SCAN_CHK;
      end

      // level scan: re-sort a full segment now under the threshold
      S_SCAN_CHK: begin
        if (rd_live <= thr_r && rd_mk == 2'b00) begin
          seg_nxt = idx_r;
          amt_nxt = $signed({1'b0, rd_live});
          state_nxt = S_RD;
        end else begin
          state_nxt = S_SCAN_NXT;
        end
      end

      // level scan: advance
      S_SCAN_NXT: begin
        if (idx_r == IDX_TOP) begin
          em_seg_nxt = NONE;  em_ret_nxt = S_IDLE;  state_nxt = S_EMIT;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);  state_nxt = S_SCAN_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // segment and link memories
  always_ff @(posedge clk) begin
    seg_rd_q  <= seg_mem[rd_addr];
    link_rd_q <= link_mem[rd_addr];
    if (seg_we) begin
      seg_mem[seg_wa] <= seg_wd;
    end
    if (lk_we_n) begin
      link_mem[lk_wa].nxt <= lk_wd_n;
    end
    if (lk_we_p) begin
      link_mem[lk_wa].prv <= lk_wd_p;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_bytes_r <= RST_SEG_BYTES;
      bsl_r       <= RST_BLOCK_LOG2;
      thr_r       <= RST_DIRTY_THR;
      floor_r     <= RST_CLEAN_FLR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SEG_BYTES:  seg_bytes_r <= cfg_wdata;
        REG_BLOCK_LOG2: bsl_r       <= cfg_wdata[LOG2_W-1:0];
        REG_DIRTY_THR:  thr_r       <= cfg_wdata;
        REG_CLEAN_FLR:  floor_r     <= cfg_wdata;
        default:        floor_r     <= floor_r;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      idx_r       <= '0;
      cur_r       <= NONE;
      chead_r     <= NONE;
      ctail_r     <= NONE;
      dhead_r     <= NONE;
      dtail_r     <= NONE;
      ccnt_r      <= '0;
      dcnt_r      <= '0;
      free_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cur_r       <= cur_nxt;
      chead_r     <= chead_nxt;
      ctail_r     <= ctail_nxt;
      dhead_r     <= dhead_nxt;
      dtail_r     <= dtail_nxt;
      ccnt_r      <= ccnt_nxt;
      dcnt_r      <= dcnt_nxt;
      free_r      <= free_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    func_r      <= func_nxt;
    seg_r       <= seg_nxt;
    amt_r       <= amt_nxt;
    prev_r      <= prev_nxt;
    nv_r        <= nv_nxt;
    diff_r      <= diff_nxt;
    dec_r       <= dec_nxt;
    mk_r        <= mk_nxt;
    rm_r        <= rm_nxt;
    ap_r        <= ap_nxt;
    p_r         <= p_nxt;
    n_r         <= n_nxt;
    ptail_r     <= ptail_nxt;
    blocks_r    <= blocks_nxt;
    walk_r      <= walk_nxt;
    found_r     <= found_nxt;
    limit_r     <= limit_nxt;
    pend_seg_r  <= pend_seg_nxt;
    pend_pos_r  <= pend_pos_nxt;
    cand_seg_r  <= cand_seg_nxt;
    cand_pos_r  <= cand_pos_nxt;
    em_status_r <= em_status_nxt;
    em_last_r   <= em_last_nxt;
    em_seg_r    <= em_seg_nxt;
    em_prev_r   <= em_prev_nxt;
    em_next_r   <= em_next_nxt;
    em_found_r  <= em_found_nxt;
    em_ret_r    <= em_ret_nxt;
    out_last_r  <= out_last_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

`default_nettype wire
